@@ design/cths_pkg.sv @@
// Shared constants, codes and transaction types for the crypt table string hash.
package cths_pkg;

  localparam int TABLE_GROUPS = 5;
  localparam int GROUP_WORDS  = 256;
  localparam int TABLE_WORDS  = TABLE_GROUPS * GROUP_WORDS;
  localparam int ADDR_W       = $clog2(TABLE_WORDS);
  localparam int GCNT_W       = $clog2(TABLE_GROUPS + 1);

  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [21:0] LCG_START    = 22'h100001;
  localparam logic [28:0] LCG_MOD      = 29'h2AAAAB;
  localparam logic [28:0] LCG_MULT     = 29'd125;
  localparam logic [28:0] LCG_INC      = 29'd3;
  // 125 < 2**7, so seven compare-subtract steps reduce the product
  localparam logic [2:0]  LCG_TOP_STEP = 3'd6;

  localparam logic [63:0] SEED_A_START = 64'h7FED7FED;
  localparam logic [63:0] SEED_B_START = 64'hEEEEEEEE;
  localparam logic [63:0] SEED_B_INC   = 64'd3;

  typedef enum logic {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    FILL_MUL,
    FILL_RED,
    FILL_DONE
  } fill_state_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  key_byte;
    logic [31:0] word;
  } queue_entry_t;

  typedef struct packed {
    logic         push;
    queue_entry_t entry;
  } queue_push_t;

  typedef struct packed {
    logic              not_empty;
    queue_entry_t      entry;
    logic [QCNT_W-1:0] count;
  } queue_status_t;

endpackage

@@ design/crypt_table_string_hash_core.sv @@
// Top level of the crypt table string hash: front end, queue and back end.
// After reset the block builds its 1280-word crypt table with a modular
// generator, each draw a multiply step followed by seven compare-subtract
// steps and two draws per word, with in_stall held high until the table is
// full; then it takes one transaction per cycle while the queue has room,
// each key byte mixed into the two 64-bit seeds by the back end's seed loop.
// A finish transaction returns the hash on out_hash_value after the table read
// register, the queue and the back end's output register, and restarts the seeds.
module crypt_table_string_hash_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_key_byte,
  input  logic [2:0]  in_table_group,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_value
);
  import cths_pkg::*;

  queue_push_t   q_push;
  queue_status_t q_status;
  logic          pop;

  cths_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_key_byte    (in_key_byte),
    .in_table_group (in_table_group),
    .q_status       (q_status),
    .q_push         (q_push)
  );

  cths_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_push   (q_push),
    .pop      (pop),
    .q_status (q_status)
  );

  cths_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_status       (q_status),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

endmodule

@@ design/cths_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cths_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1280
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/cths_front.sv @@
// Front end: crypt table fill sequencer, input acceptance and table lookup.
module cths_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_op,
  input  logic [7:0]              in_key_byte,
  input  logic [2:0]              in_table_group,
  input  cths_pkg::queue_status_t q_status,
  output cths_pkg::queue_push_t   q_push
);
  import cths_pkg::*;

  fill_state_t       fill_st_r, fill_st_nxt;
  logic [28:0]       lcg_x_r, lcg_x_nxt;
  logic [21:0]       seed_r, seed_nxt;
  logic              half_r, half_nxt;
  logic [15:0]       hi_r, hi_nxt;
  logic [2:0]        red_k_r, red_k_nxt;
  logic [7:0]        j_r, j_nxt;
  logic [GCNT_W-1:0] g_r, g_nxt;

  logic [28:0]       red_thr;
  logic [28:0]       red_x;
  logic              last_word;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]       ram_rdata;

  logic              fill_done;
  logic              no_room;
  logic              in_accept;
  logic              grp_ok;

  logic              s1_v_r;
  op_t               s1_op_r;
  logic [7:0]        s1_key_r;
  logic              s1_ok_r;

  // one conditional subtract of MOD * 2**k per cycle
  assign red_thr   = LCG_MOD << red_k_r;
  assign red_x     = (lcg_x_r >= red_thr) ? (lcg_x_r - red_thr) : lcg_x_r;
  assign last_word = (g_r == GCNT_W'(TABLE_GROUPS - 1)) && (j_r == 8'(GROUP_WORDS - 1));

  always_comb begin
    fill_st_nxt = fill_st_r;
    case (fill_st_r)
      FILL_MUL: fill_st_nxt = FILL_RED;
      FILL_RED: begin
        if (red_k_r == 3'd0) begin
          fill_st_nxt = (half_r && last_word) ? FILL_DONE : FILL_MUL;
        end
      end
      FILL_DONE: fill_st_nxt = FILL_DONE;
      default:   fill_st_nxt = FILL_DONE;
    endcase
  end

  always_comb begin
    lcg_x_nxt = lcg_x_r;
    seed_nxt  = seed_r;
    half_nxt  = half_r;
    hi_nxt    = hi_r;
    red_k_nxt = red_k_r;
    j_nxt     = j_r;
    g_nxt     = g_r;
    ram_we    = 1'b0;
    ram_wdata = {hi_r, red_x[15:0]};
    case (fill_st_r)
      FILL_MUL: begin
        lcg_x_nxt = {7'd0, seed_r} * LCG_MULT + LCG_INC;
        red_k_nxt = LCG_TOP_STEP;
      end
      FILL_RED: begin
        lcg_x_nxt = red_x;
        red_k_nxt = red_k_r - 3'd1;
        if (red_k_r == 3'd0) begin
          seed_nxt = red_x[21:0];
          if (!half_r) begin
            hi_nxt   = red_x[15:0];
            half_nxt = 1'b1;
          end else begin
            half_nxt = 1'b0;
            ram_we   = 1'b1;
            // groups inner, byte index outer
            if (g_r == GCNT_W'(TABLE_GROUPS - 1)) begin
              g_nxt = '0;
              j_nxt = j_r + 8'd1;
            end else begin
              g_nxt = g_r + GCNT_W'(1);
            end
          end
        end
      end
      FILL_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_st_r <= FILL_MUL;
      seed_r    <= LCG_START;
      half_r    <= 1'b0;
      red_k_r   <= LCG_TOP_STEP;
      j_r       <= '0;
      g_r       <= '0;
    end else begin
      fill_st_r <= fill_st_nxt;
      seed_r    <= seed_nxt;
      half_r    <= half_nxt;
      red_k_r   <= red_k_nxt;
      j_r       <= j_nxt;
      g_r       <= g_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lcg_x_r <= lcg_x_nxt;
    hi_r    <= hi_nxt;
  end

  assign ram_waddr = ADDR_W'({g_r, j_r});
  assign ram_raddr = ADDR_W'({in_table_group, in_key_byte});

  cths_ram #(
    .WIDTH(32),
    .DEPTH(TABLE_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // count the lookup in flight against the queue space
  assign fill_done = (fill_st_r == FILL_DONE);
  assign no_room   = ({1'b0, q_status.count} + (QCNT_W + 1)'(s1_v_r))
                     >= (QCNT_W + 1)'(QUEUE_DEPTH);
  assign in_stall  = !fill_done || no_room;
  assign in_accept = in_valid && !in_stall;
  assign grp_ok    = ({2'b00, in_table_group} < 5'(TABLE_GROUPS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r  <= op_t'(in_op);
      s1_key_r <= in_key_byte;
      s1_ok_r  <= grp_ok;
    end
  end

  always_comb begin
    q_push.push           = s1_v_r;
    q_push.entry.op       = s1_op_r;
    q_push.entry.key_byte = s1_key_r;
    q_push.entry.word     = s1_ok_r ? ram_rdata : 32'd0;
  end

`ifndef ASSERT_OFF
  a_accept_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> fill_st_r == FILL_DONE)
    else $error("transaction accepted before table fill completed");
`endif

endmodule

@@ design/cths_fifo.sv @@
// Short queue of looked-up transactions between the front and back ends.
module cths_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cths_pkg::queue_push_t   q_push,
  input  logic                    pop,
  output cths_pkg::queue_status_t q_status
);
  import cths_pkg::*;

  queue_entry_t      mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_push.push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    case ({q_push.push, pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      mem_r[wr_ptr_r] <= q_push.entry;
    end
  end

  assign q_status.not_empty = (count_r != '0);
  assign q_status.entry     = mem_r[rd_ptr_r];
  assign q_status.count     = count_r;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.push |-> count_r < QCNT_W'(QUEUE_DEPTH))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue pop while empty");
`endif

endmodule

@@ design/cths_back.sv @@
// Back end: seed mixing per key byte and the registered hash output.
module cths_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cths_pkg::queue_status_t q_status,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [63:0]             out_hash_value
);
  import cths_pkg::*;

  logic [63:0] seed_a_r, seed_a_nxt;
  logic [63:0] seed_b_r, seed_b_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_hash_r, out_hash_nxt;

  logic        is_finish;
  logic        pop_finish;
  logic [63:0] sum_ab;
  logic [63:0] mix_a;
  logic [63:0] part_b;

  assign is_finish  = (q_status.entry.op == OP_FINISH);
  // absorbs never wait; a finish waits for the output register
  assign pop        = q_status.not_empty && (!is_finish || !out_valid_r || !out_stall);
  assign pop_finish = pop && is_finish;

  assign sum_ab = seed_a_r + seed_b_r;
  assign mix_a  = {32'd0, q_status.entry.word} ^ sum_ab;
  assign part_b = seed_b_r + (seed_b_r << 5) + {56'd0, q_status.entry.key_byte} + SEED_B_INC;

  always_comb begin
    seed_a_nxt    = seed_a_r;
    seed_b_nxt    = seed_b_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (pop) begin
      if (is_finish) begin
        out_hash_nxt  = seed_a_r;
        out_valid_nxt = 1'b1;
        seed_a_nxt    = SEED_A_START;
        seed_b_nxt    = SEED_B_START;
      end else begin
        seed_a_nxt = mix_a;
        seed_b_nxt = mix_a + part_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_a_r    <= SEED_A_START;
      seed_b_r    <= SEED_B_START;
      out_valid_r <= 1'b0;
    end else begin
      seed_a_r    <= seed_a_nxt;
      seed_b_r    <= seed_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hash_r <= out_hash_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

`ifndef ASSERT_OFF
  a_restart_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    pop_finish |=> seed_a_r == SEED_A_START && seed_b_r == SEED_B_START)
    else $error("seeds not restarted after finish");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pop_finish))
    else $error("result raised without a finish transaction");
`endif

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the crypt table string hash core.
`timescale 1ns / 1ps

module tb_top;
  import cths_pkg::*;

  localparam int          ITEM_TARGET  = 1150;
  localparam int          CALM_ITEMS   = 120;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [31:0] GEN_MOD      = 32'h2AAAAB;
  localparam logic [31:0] GEN_MULT     = 32'd125;
  localparam logic [31:0] GEN_INC      = 32'd3;

  typedef struct {
    op_t        op;
    logic [7:0] key_byte;
    logic [2:0] table_group;
  } key_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = 1'b0;
  logic [7:0]  in_key_byte = 8'd0;
  logic [2:0]  in_table_group = 3'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_hash_value;

  key_item_t   key_items[$];
  logic [63:0] hash_expect_q[$];
  logic [31:0] crypt_word_tbl[TABLE_WORDS];
  logic [63:0] mix_a;
  logic [63:0] mix_b;

  logic        in_fire = 1'b0;
  int          cycle_cnt = 0;
  int          n_total = 0;
  int          n_taken = 0;
  int          n_errors = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          drv_mode = 0;
  int          rcv_mode = 0;

  crypt_table_string_hash_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_key_byte    (in_key_byte),
    .in_table_group (in_table_group),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

  always #4 clk = ~clk;

  // Two generator draws per word, j-major and group-minor, as the block fills it.
  function automatic void fill_crypt_words();
    logic [31:0] gen;
    logic [31:0] hi;
    gen = {10'd0, LCG_START};
    for (int j = 0; j < GROUP_WORDS; j++) begin
      for (int g = 0; g < TABLE_GROUPS; g++) begin
        gen = (gen * GEN_MULT + GEN_INC) % GEN_MOD;
        hi = {gen[15:0], 16'd0};
        gen = (gen * GEN_MULT + GEN_INC) % GEN_MOD;
        crypt_word_tbl[g * GROUP_WORDS + j] = hi | {16'd0, gen[15:0]};
      end
    end
  endfunction

  function automatic void mix_key_byte(logic [7:0] ch, logic [2:0] grp);
    logic [63:0] w;
    w = 64'd0;
    // groups past the table read as zero
    if (grp < TABLE_GROUPS)
      w = {32'd0, crypt_word_tbl[grp * GROUP_WORDS + ch]};
    mix_a = w ^ (mix_a + mix_b);
    mix_b = {56'd0, ch} + mix_a + mix_b + (mix_b << 5) + 64'd3;
  endfunction

  function automatic bit take_break(int mode);
    if (mode == 1)
      return $urandom_range(0, 7) == 0;
    if (mode == 2)
      return $urandom_range(0, 1) == 0;
    return 1'b0;
  endfunction

  task automatic add_item(op_t op, logic [7:0] kb, logic [2:0] grp);
    key_item_t it;
    it.op = op;
    it.key_byte = kb;
    it.table_group = grp;
    key_items = {key_items, it};
  endtask

  task automatic report_mismatch(logic [63:0] exp_v, logic [63:0] got_v, bit orphan);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      if (orphan)
        $display("ERROR @%0t: unexpected hash %h", $time, got_v);
      else
        $display("ERROR @%0t: hash expected %h got %h", $time, exp_v, got_v);
    end
  endtask

  // Driver: hold the payload until taken, insert random gaps.
  always @(negedge clk) begin : drive
    key_item_t nxt;
    if (cycle_cnt % 97 == 0)
      drv_mode <= $urandom_range(0, 2);
    if (rst_n && (!in_valid || in_fire)) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (key_items.size() != 0 && key_items.size() >= CALM_ITEMS &&
                   take_break(drv_mode)) begin
        in_valid <= 1'b0;
        gap_left <= $urandom_range(0, 9);
      end else if (key_items.size() != 0) begin
        nxt = key_items.pop_front();
        in_valid <= 1'b1;
        in_op <= nxt.op;
        in_key_byte <= nxt.key_byte;
        in_table_group <= nxt.table_group;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off midway so the queue backs up into in_stall.
  always @(negedge clk) begin
    if (!hold_done && n_total != 0 && n_taken >= n_total / 2) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (cycle_cnt % 89 == 0)
      rcv_mode <= $urandom_range(0, 2);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (key_items.size() >= CALM_ITEMS && take_break(rcv_mode)) begin
      stall_left <= $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= hold_left != 0;
    end
  end

  // Monitor: predict on each accepted input, check each accepted hash.
  always @(posedge clk) begin
    logic [63:0] exp_v;
    cycle_cnt <= cycle_cnt + 1;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      n_taken <= n_taken + 1;
      if (op_t'(in_op) == OP_FINISH) begin
        hash_expect_q = {hash_expect_q, mix_a};
        mix_a = SEED_A_START;
        mix_b = SEED_B_START;
      end else begin
        mix_key_byte(in_key_byte, in_table_group);
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (hash_expect_q.size() == 0) begin
        report_mismatch(64'd0, out_hash_value, 1'b1);
      end else begin
        exp_v = hash_expect_q.pop_front();
        if (out_hash_value !== exp_v)
          report_mismatch(exp_v, out_hash_value, 1'b0);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int klen;
    int kind;
    logic [2:0] grp;
    fill_crypt_words();
    mix_a = SEED_A_START;
    mix_b = SEED_B_START;

    // empty keys back to back
    add_item(OP_FINISH, 8'h00, 3'd0);
    add_item(OP_FINISH, 8'h00, 3'd0);
    // byte extremes at both ends of the table
    add_item(OP_ABSORB, 8'h00, 3'd0);
    add_item(OP_ABSORB, 8'hFF, 3'd4);
    add_item(OP_FINISH, 8'h5A, 3'd2);
    // groups past the table, bytes with and without the sign bit set
    add_item(OP_ABSORB, 8'h80, 3'd5);
    add_item(OP_ABSORB, 8'h7F, 3'd6);
    add_item(OP_ABSORB, 8'hAA, 3'd7);
    add_item(OP_FINISH, 8'hFF, 3'd7);
    for (int g = 0; g < TABLE_GROUPS; g++)
      add_item(OP_ABSORB, 8'h55, g[2:0]);
    add_item(OP_FINISH, 8'h00, 3'd0);
    add_item(OP_ABSORB, 8'hFF, 3'd7);
    add_item(OP_FINISH, 8'h01, 3'd1);

    // random keys: mostly one group per key, some with per-byte noise groups
    while (key_items.size() < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      klen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
      grp = 3'($urandom_range(0, 4));
      for (int k = 0; k < klen; k++)
        add_item(OP_ABSORB, 8'($urandom_range(0, 255)),
                 (kind == 0) ? 3'($urandom_range(0, 7)) : grp);
      add_item(OP_FINISH, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
    end
    n_total = key_items.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_taken < n_total)
      @(posedge clk);
    while (hash_expect_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ files.f @@
design/cths_pkg.sv
design/cths_ram.sv
design/cths_front.sv
design/cths_fifo.sv
design/cths_back.sv
design/crypt_table_string_hash_core.sv
bench/tb_top.sv
